FILE: rtl/core/indexed_vector_table_engine_defines.svh
// Assertion macros for the indexed vector table engine.
`ifndef INDEXED_VECTOR_TABLE_ENGINE_DEFINES_SVH
`define INDEXED_VECTOR_TABLE_ENGINE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define IVTE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Checked on every clock edge, reset included.
`define IVTE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define IVTE_ASSERT(label, prop, msg)
`define IVTE_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: rtl/core/ivte_pkg.sv
// Shared types and constants for the indexed vector table engine.
package ivte_pkg;

   localparam int DEPTH_DEFAULT     = 64;
   localparam int DATA_BITS_DEFAULT = 64;
   localparam int WORD_BITS         = 64;
   localparam int TYPE_BITS         = 3;
   localparam int STATUS_BITS       = 2;

   // Request operation codes
   typedef enum logic [TYPE_BITS-1:0] {
      OP_PUSH   = 3'd0,
      OP_POP    = 3'd1,
      OP_INSERT = 3'd2,
      OP_AT     = 3'd3,
      OP_ERASE  = 3'd4
   } op_type;

   // Result status codes
   typedef enum logic [STATUS_BITS-1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_EMPTY = 2'd2,
      STS_RANGE = 2'd3
   } status_type;

endpackage

FILE: rtl/core/indexed_vector_table_engine.sv
// Sequence: push, failed and unknown requests go from IDLE to DONE; pop and read pass IDLE, READ, DONE.
// An insert that moves entries passes SHIFT, then FILL and DONE; an erase that moves entries, SHIFT then DONE.
// One item in flight; the shift rate is one entry per cycle, set by the single 1R1W store.
// The next item is taken once the result is loaded, while that result may still wait.
// Reset clears the used count and all control; the entry store is not cleared.
`include "indexed_vector_table_engine_defines.svh"

module indexed_vector_table_engine #(
   parameter int DEPTH     = ivte_pkg::DEPTH_DEFAULT,
   parameter int DATA_BITS = ivte_pkg::DATA_BITS_DEFAULT,
   localparam int POS_BITS = $clog2(DEPTH + 1)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [ivte_pkg::TYPE_BITS-1:0]        req_type,
   input  logic [POS_BITS-1:0]                   req_position,
   input  logic [ivte_pkg::WORD_BITS-1:0]        req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [ivte_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic [ivte_pkg::WORD_BITS-1:0]        rsp_read_data,
   output logic [POS_BITS-1:0]                   rsp_used_count,
   output logic                                  rsp_is_empty
);
   import ivte_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [POS_BITS-1:0] FULL_COUNT = POS_BITS'(DEPTH);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_READ  = 5'b00010,
      ST_SHIFT = 5'b00100,
      ST_FILL  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   // Entry store and its registered read port
   logic [DATA_BITS-1:0] entry_store_mem [DEPTH];
   logic [DATA_BITS-1:0] mem_q_ff;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [DATA_BITS-1:0] mem_wdata;
   logic                 mem_re;
   logic [AW-1:0]        mem_raddr;

   // Control and item registers
   state_type            state_ff, state_in;
   logic [POS_BITS-1:0]  used_ff, used_in;
   op_type               op_ff, op_in;
   logic [POS_BITS-1:0]  pos_ff, pos_in;
   logic [DATA_BITS-1:0] word_ff, word_in;
   status_type           status_ff, status_in;
   logic                 has_data_ff, has_data_in;
   logic [AW-1:0]        rd_idx_ff, rd_idx_in;
   logic                 rd_more_ff, rd_more_in;
   logic                 pend_ff, pend_in;
   logic [AW-1:0]        wr_idx_ff, wr_idx_in;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [WORD_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [POS_BITS-1:0]  rsp_used_ff, rsp_used_in;
   logic                 rsp_empty_ff, rsp_empty_in;

   logic                 accept;
   logic                 out_free;
   logic                 is_full;
   logic                 is_zero;
   logic [POS_BITS-1:0]  used_dec;
   logic [POS_BITS-1:0]  used_inc;
   logic                 shift_last;
   logic                 full_push;
   op_type               req_op;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_full   = (used_ff == FULL_COUNT);
   assign is_zero   = (used_ff == '0);
   assign used_dec  = used_ff - POS_BITS'(1);
   assign used_inc  = used_ff + POS_BITS'(1);
   assign req_op    = op_type'(req_type);
   assign full_push = accept && (req_op == OP_PUSH) && is_full;

   // Last read of a shift: insert walks down to the position, erase up to the new end
   assign shift_last = (op_ff == OP_INSERT) ? (rd_idx_ff == AW'(pos_ff))
                                            : (rd_idx_ff == AW'(used_ff));

   // Sequencer: decode on accept, then walk the store
   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      word_in      = word_ff;
      status_in    = status_ff;
      has_data_in  = has_data_ff;
      rd_idx_in    = rd_idx_ff;
      rd_more_in   = rd_more_ff;
      pend_in      = 1'b0;
      wr_idx_in    = wr_idx_ff;
      mem_we       = 1'b0;
      mem_waddr    = AW'(used_ff);
      mem_wdata    = req_data[DATA_BITS-1:0];
      mem_re       = 1'b0;
      mem_raddr    = rd_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_used_in  = rsp_used_ff;
      rsp_empty_in = rsp_empty_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in       = req_op;
               pos_in      = req_position;
               word_in     = req_data[DATA_BITS-1:0];
               status_in   = STS_OK;
               has_data_in = 1'b0;
               rd_more_in  = 1'b0;
               state_in    = ST_DONE;
               unique case (req_op)
                  OP_PUSH: begin
                     if (is_full) begin
                        status_in = STS_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(used_ff);
                        used_in   = used_inc;
                     end
                  end
                  OP_POP: begin
                     if (is_zero) begin
                        status_in = STS_EMPTY;
                     end else begin
                        mem_re      = 1'b1;
                        mem_raddr   = AW'(used_dec);
                        used_in     = used_dec;
                        has_data_in = 1'b1;
                        state_in    = ST_READ;
                     end
                  end
                  OP_INSERT: begin
                     if (req_position > used_ff) begin
                        status_in = STS_RANGE;
                     end else if (is_full) begin
                        status_in = STS_FULL;
                     end else if (req_position == used_ff) begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(req_position);
                        used_in   = used_inc;
                     end else begin
                        rd_idx_in  = AW'(used_dec);
                        rd_more_in = 1'b1;
                        used_in    = used_inc;
                        state_in   = ST_SHIFT;
                     end
                  end
                  OP_AT: begin
                     if (is_zero) begin
                        status_in = STS_EMPTY;
                     end else if (req_position >= used_ff) begin
                        status_in = STS_RANGE;
                     end else begin
                        mem_re      = 1'b1;
                        mem_raddr   = AW'(req_position);
                        has_data_in = 1'b1;
                        state_in    = ST_READ;
                     end
                  end
                  OP_ERASE: begin
                     if (is_zero) begin
                        status_in = STS_EMPTY;
                     end else if (req_position >= used_ff) begin
                        status_in = STS_RANGE;
                     end else begin
                        used_in = used_dec;
                        if (req_position != used_dec) begin
                           rd_idx_in  = AW'(req_position + POS_BITS'(1));
                           rd_more_in = 1'b1;
                           state_in   = ST_SHIFT;
                        end
                     end
                  end
                  default: begin
                     // unknown code: no change, plain ok result
                  end
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_SHIFT: begin
            // write back the word read last cycle, read the next one
            mem_we    = pend_ff;
            mem_waddr = wr_idx_ff;
            mem_wdata = mem_q_ff;
            if (rd_more_ff) begin
               mem_re     = 1'b1;
               mem_raddr  = rd_idx_ff;
               pend_in    = 1'b1;
               rd_more_in = !shift_last;
               if (op_ff == OP_INSERT) begin
                  wr_idx_in = rd_idx_ff + AW'(1);
                  rd_idx_in = rd_idx_ff - AW'(1);
               end else begin
                  wr_idx_in = rd_idx_ff - AW'(1);
                  rd_idx_in = rd_idx_ff + AW'(1);
               end
            end else begin
               state_in = (op_ff == OP_INSERT) ? ST_FILL : ST_DONE;
            end
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = AW'(pos_ff);
            mem_wdata = word_ff;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_data_in   = has_data_ff ? WORD_BITS'(mem_q_ff) : '0;
               rsp_used_in   = used_ff;
               rsp_empty_in  = is_zero;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_store_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= entry_store_mem[mem_raddr];
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         rd_more_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         rd_more_ff   <= rd_more_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      pos_ff        <= pos_in;
      word_ff       <= word_in;
      status_ff     <= status_in;
      has_data_ff   <= has_data_in;
      rd_idx_ff     <= rd_idx_in;
      wr_idx_ff     <= wr_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_used_ff   <= rsp_used_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_used_count = rsp_used_ff;
   assign rsp_is_empty   = rsp_empty_ff;

   // Checks
   `IVTE_ASSERT(a_used_in_bound, used_ff <= FULL_COUNT, "used count beyond depth")
   `IVTE_ASSERT(a_full_push_keeps, full_push |=> $stable(used_ff), "full push changed count")
   `IVTE_ASSERT(a_shift_drain, (state_ff == ST_SHIFT && !rd_more_ff) |-> pend_ff,
      "shift ended without a pending write")
   `IVTE_ASSERT(a_error_no_data,
      (rsp_valid_ff && rsp_status_ff != STS_OK) |-> (rsp_data_ff == '0),
      "read data on failed item")
   `IVTE_ASSERT_ALWAYS(a_reset_idle, reset |=> (state_ff == ST_IDLE && !rsp_valid_ff),
      "not idle after reset")

endmodule
